### src/fcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg
// Constants shared by the cube root datapath: fit coefficients in decimal
// fixed point (times 10^16) and the decimal scale used to convert them.
// ----------------------------------------------------------------------------
package fcr_pkg;

	// numerator high to low, denominator high to low, then 1.0
	localparam logic [63:0] DEC_COEF [10] = '{
		64'd452548339756803023, 64'd1922798368355061050, 64'd1191654824285581629,
		64'd134325013908623987, 64'd1636161226585754,
		64'd148088409321913457, 64'd1519714051044435649, 64'd1685254414101568284,
		64'd339905941350215599, 64'd10000000000000000
	};
	localparam logic [127:0] DEC_ONE  = 128'd10000000000000000;
	localparam logic [127:0] DEC_HALF = 128'd5000000000000000;

endpackage

### src/float_cube_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_cube_root
// Pipelined cube root of an IEEE double, rational fit in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Operands arrive on the s_axis stream (raw double bit patterns), results
//   leave on the m_axis stream in the same order, one result per operand.
//   One transfer can be taken every cycle while the output is not stalled;
//   items are fully independent. The pipeline has three front stages
//   (decode, normalise, range reduction), eight Horner stages (four steps,
//   each a partial-product stage and a sum stage), one restoring divider
//   stage per quotient bit (FRACTION_BITS + 2) and two stages that
//   normalise the quotient and assemble the result.
//   The whole pipeline advances on one enable; when the receiver holds
//   m_axis_tready low with a result waiting, every stage holds, nothing is
//   dropped or repeated, and s_axis_tready falls in the same cycle.
//   While the last stage is empty the pipe advances whatever m_axis_tready
//   does; bubbles further up are not squeezed out during a stall.
//   Reset (arst_n low) clears every stage valid bit; payload is not reset.
//   Zero, infinity and NaN pass through unchanged.
// ----------------------------------------------------------------------------
module float_cube_root #(
	parameter int FRACTION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] value_bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [63:0] root_bits
);
	import fcr_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int AW = F + 9;
	localparam int RL = F / 2;
	localparam int RH = F - RL;
	localparam int QW = F + 2;
	localparam int DX = QW - F;
	localparam int PW = $clog2(QW);
	localparam int DS = 12;
	localparam int P1 = DS + QW;
	localparam int NS = P1 + 1;

	function automatic logic [AW-1:0] coef_q(input int idx);
		logic [127:0] n;
		n = ({64'd0, DEC_COEF[idx]} << FRACTION_BITS) + DEC_HALF;
		return AW'(n / DEC_ONE);
	endfunction

	localparam logic [AW-1:0] COEF [10] = '{
		coef_q(0), coef_q(1), coef_q(2), coef_q(3), coef_q(4),
		coef_q(5), coef_q(6), coef_q(7), coef_q(8), coef_q(9)
	};

	logic adv;
	logic vld_s  [1:NS];
	logic [63:0] x_s [1:P1];
	logic spec_s [1:P1];
	logic signed [10:0] k_s [3:P1];

	assign adv           = !vld_s[NS] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= NS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// ---------------- stage 1: decode, leading one of a subnormal
	logic [10:0] expf_in;
	logic [51:0] frac_in;
	logic        spec_in;
	logic [5:0]  z_in;
	logic [5:0]  z_s1;
	logic        sub_s1;

	assign expf_in = s_axis_tdata[62:52];
	assign frac_in = s_axis_tdata[51:0];
	assign spec_in = (expf_in == 11'h7FF) || (s_axis_tdata[62:0] == 63'd0);

	always_comb begin
		z_in = 6'd52;
		for (int b = 0; b < 52; b++) begin
			if (frac_in[b]) z_in = 6'(52 - b);
		end
	end

	// ---------------- stage 2: normalised mantissa, biased exponent e + 3000
	logic [52:0] m_s2, m_s3;
	logic [11:0] v_s2;

	// ---------------- stage 3: residue mod 3, shift to Q(F)
	logic [23:0] v3p;
	logic [11:0] q3;
	logic [1:0]  rsd;
	logic [5:0]  rsh;
	logic signed [10:0] k_new;
	logic [F-1:0] r_s [3:9];

	assign v3p   = 24'(v_s2) * 24'd2731;
	assign q3    = v3p[23:12] >> 1;
	assign rsd   = 2'(v_s2 - 12'(q3 * 12'd3));
	assign k_new = 11'($signed({1'b0, q3}) - 13'sd1000) + ((rsd != 2'd0) ? 11'sd1 : 11'sd0);
	assign rsh   = 6'(53 - F) + ((rsd == 2'd0) ? 6'd0 : 6'(3 - rsd));
	assign m_s3  = m_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[1]    <= s_axis_tdata;
			spec_s[1] <= spec_in;
			z_s1      <= z_in;
			sub_s1    <= (expf_in == 11'd0);
			for (int i = 2; i <= P1; i++) begin
				x_s[i]    <= x_s[i-1];
				spec_s[i] <= spec_s[i-1];
			end
			m_s2 <= sub_s1 ? (53'(x_s[1][51:0]) << z_s1) : {1'b1, x_s[1][51:0]};
			v_s2 <= sub_s1 ? (12'd1979 - 12'(z_s1)) : (12'(x_s[1][62:52]) + 12'd1978);
			k_s[3] <= k_new;
			for (int i = 4; i <= P1; i++) k_s[i] <= k_s[i-1];
			r_s[3] <= F'(m_s3 >> rsh);
			for (int i = 4; i <= 9; i++) r_s[i] <= r_s[i-1];
		end
	end

	// ---------------- Horner steps: stages 4..11
	logic [AW+RL-1:0] pln_s [0:3];
	logic [AW+RH-1:0] phn_s [0:3];
	logic [AW+RL-1:0] pld_s [0:3];
	logic [AW+RH-1:0] phd_s [0:3];
	logic [AW-1:0]    accn_s [0:3];
	logic [AW-1:0]    accd_s [0:3];

	for (genvar j = 0; j < 4; j++) begin : g_horner
		logic [AW-1:0]   an, ad;
		logic [F-1:0]    rv;
		logic [AW+F-1:0] sn, sd;
		if (j == 0) begin : g_first
			assign an = COEF[0];
			assign ad = COEF[5];
		end else begin : g_next
			assign an = accn_s[j-1];
			assign ad = accd_s[j-1];
		end
		assign rv = r_s[3 + 2*j];
		assign sn = (AW+F)'(pln_s[j]) + ((AW+F)'(phn_s[j]) << RL);
		assign sd = (AW+F)'(pld_s[j]) + ((AW+F)'(phd_s[j]) << RL);
		always_ff @(posedge clk) begin
			if (adv) begin
				pln_s[j]  <= an * rv[RL-1:0];
				phn_s[j]  <= an * rv[F-1:RL];
				pld_s[j]  <= ad * rv[RL-1:0];
				phd_s[j]  <= ad * rv[F-1:RL];
				accn_s[j] <= AW'(sn >> F) + COEF[j+1];
				accd_s[j] <= AW'(sd >> F) + COEF[j+6];
			end
		end
	end

	// ---------------- restoring divider, one quotient bit per stage
	logic [AW-1:0] rem_s [0:QW-2];
	logic [AW-1:0] dn_s  [0:QW-2];
	logic [DX-1:0] nl_s  [0:QW-2];
	logic [QW-1:0] q_s   [0:QW-1];

	for (genvar t = 0; t < QW; t++) begin : g_div
		localparam int BI = QW - 1 - t;
		logic [AW-1:0] rin, din;
		logic [DX-1:0] nin;
		logic [QW-1:0] qin;
		logic          bv, ge;
		logic [AW:0]   sh;
		if (t == 0) begin : g_first
			assign rin = accn_s[3] >> DX;
			assign din = accd_s[3];
			assign nin = accn_s[3][DX-1:0];
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[t-1];
			assign din = dn_s[t-1];
			assign nin = nl_s[t-1];
			assign qin = q_s[t-1];
		end
		if (BI >= F) begin : g_nbit
			assign bv = nin[BI-F];
		end else begin : g_zbit
			assign bv = 1'b0;
		end
		assign sh = {rin, bv};
		assign ge = sh >= {1'b0, din};
		always_ff @(posedge clk) begin
			if (adv) q_s[t] <= {qin[QW-2:0], ge};
		end
		if (t < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[t] <= ge ? AW'(sh - {1'b0, din}) : AW'(sh);
					dn_s[t]  <= din;
					nl_s[t]  <= nin;
				end
			end
		end
	end

	// ---------------- quotient normalise and result assembly
	logic [QW-1:0] qf;
	logic [PW-1:0] pc;
	logic [PW-1:0] p_s1;
	logic [QW-1:0] qn_s1;
	logic          qz_s1;
	logic [52:0]   mant;
	logic [10:0]   bexp;
	logic [63:0]   out_q;

	assign qf = q_s[QW-1];

	always_comb begin
		pc = '0;
		for (int b = 0; b < QW; b++) begin
			if (qf[b]) pc = PW'(b);
		end
	end

	assign mant = 53'({qn_s1, 53'd0} >> QW);
	assign bexp = 11'(int'(p_s1) - F + int'(k_s[P1]) + 1023);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1  <= pc;
			qn_s1 <= qf << (PW'(QW - 1) - pc);
			qz_s1 <= (qf == '0);
			if (spec_s[P1]) out_q <= x_s[P1];
			else if (qz_s1) out_q <= {x_s[P1][63], 63'd0};
			else out_q <= {x_s[P1][63], bexp, mant[51:0]};
		end
	end

	assign m_axis_tdata = out_q;

endmodule
